// File: sv/mspd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspd_pkg - shared types for the motor speed pid drive
// Mode codes, register indexes, sequencer states, control/status structs
// and the symmetric clamp used by the datapath.
// ----------------------------------------------------------------------------
package mspd_pkg;

  // field widths
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned LIMIT_W = 15;
  localparam int unsigned ERR_W   = SPEED_W + 1;
  localparam int unsigned DERR_W  = ERR_W + 1;
  localparam int unsigned ADDR_W  = 3;

  // shared multiplier operand and product widths
  localparam int unsigned MUL_A_W = 36;
  localparam int unsigned MUL_B_W = 18;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // widths of the scaled terms
  localparam int unsigned INC_W   = 26;
  localparam int unsigned PTERM_W = 25;
  localparam int unsigned DTERM_W = 43;
  localparam int unsigned SUM_W   = 44;

  // direct mode bound
  localparam logic [LIMIT_W-1:0] DIRECT_LIMIT = 15'd255;

  // operating modes (the spare code behaves as off)
  typedef enum logic [1:0] {
    CMD_OFF    = 2'd0,
    CMD_PID    = 2'd1,
    CMD_DIRECT = 2'd2
  } cmd_t;

  // configuration register indexes
  typedef enum logic [ADDR_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_TICK_PERIOD = 3'd3,
    REG_TICK_RATE   = 3'd4,
    REG_INTEG_LIMIT = 3'd5,
    REG_DRIVE_LIMIT = 3'd6
  } reg_idx_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MKI,
    ST_MDT,
    ST_MKP,
    ST_MRT,
    ST_MKD,
    ST_DSH,
    ST_SUM,
    ST_DIRECT,
    ST_FIN
  } state_t;

  // multiplier operand selection
  typedef enum logic [2:0] {
    MUL_KI,
    MUL_DT,
    MUL_KP,
    MUL_RATE,
    MUL_KD
  } mul_sel_t;

  // register file contents
  typedef struct packed {
    logic signed [GAIN_W-1:0] prop_gain;
    logic signed [GAIN_W-1:0] integ_gain;
    logic signed [GAIN_W-1:0] deriv_gain;
    logic [SPEED_W-1:0]       tick_period;
    logic [SPEED_W-1:0]       tick_rate;
    logic [LIMIT_W-1:0]       integ_limit;
    logic [LIMIT_W-1:0]       drive_limit;
  } cfg_t;

  // sequencer to datapath commands
  typedef struct packed {
    logic     in_load;
    logic     err_load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     inc_load;
    logic     p_load;
    logic     integ_load;
    logic     d_load;
    logic     pid_commit;
    logic     direct_commit;
    logic     out_load;
  } dp_cmd_t;

  // datapath to sequencer status
  typedef struct packed {
    logic [1:0] mode;
    logic       out_free;
  } dp_sts_t;

  // clamp to +-lim, result fits the speed width
  function automatic logic signed [SPEED_W-1:0] clamp_sym(
    input logic signed [SUM_W-1:0] v,
    input logic [LIMIT_W-1:0]      lim
  );
    logic signed [SUM_W-1:0]   pos;
    logic signed [SUM_W-1:0]   neg;
    logic signed [SPEED_W-1:0] res;
    pos = signed'({{(SUM_W-LIMIT_W){1'b0}}, lim});
    neg = -pos;
    if (v > pos) begin
      res = pos[SPEED_W-1:0];
    end else if (v < neg) begin
      res = neg[SPEED_W-1:0];
    end else begin
      res = v[SPEED_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: sv/mspd_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspd_cfg - configuration register file
// Gains, tick period and rate and the two clamp bounds, written by index.
// ----------------------------------------------------------------------------
module mspd_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mspd_pkg::ADDR_W-1:0]   cfg_addr,
  input  logic [mspd_pkg::SPEED_W-1:0]  cfg_data,
  output mspd_pkg::cfg_t                cfg
);

  mspd_pkg::cfg_t regs_r;

  // writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg         = regs_r;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.prop_gain   <= '0;
      regs_r.integ_gain  <= '0;
      regs_r.deriv_gain  <= '0;
      regs_r.tick_period <= '0;
      regs_r.tick_rate   <= '0;
      regs_r.integ_limit <= '0;
      regs_r.drive_limit <= mspd_pkg::DIRECT_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        mspd_pkg::REG_PROP_GAIN:   regs_r.prop_gain   <= signed'(cfg_data);
        mspd_pkg::REG_INTEG_GAIN:  regs_r.integ_gain  <= signed'(cfg_data);
        mspd_pkg::REG_DERIV_GAIN:  regs_r.deriv_gain  <= signed'(cfg_data);
        mspd_pkg::REG_TICK_PERIOD: regs_r.tick_period <= cfg_data;
        mspd_pkg::REG_TICK_RATE:   regs_r.tick_rate   <= cfg_data;
        mspd_pkg::REG_INTEG_LIMIT: regs_r.integ_limit <= cfg_data[mspd_pkg::LIMIT_W-1:0];
        mspd_pkg::REG_DRIVE_LIMIT: regs_r.drive_limit <= cfg_data[mspd_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// File: sv/mspd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspd_ctrl - tick sequencer
// Steps one control tick through error, five shared products in pid mode, the clamps
// and the result register.
// ----------------------------------------------------------------------------
module mspd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  mspd_pkg::dp_sts_t sts,
  output mspd_pkg::dp_cmd_t cmd
);

  mspd_pkg::state_t state_r;
  mspd_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mspd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mspd_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = mspd_pkg::ST_ERR;
      end
      mspd_pkg::ST_ERR: begin
        case (sts.mode)
          mspd_pkg::CMD_PID:    state_nxt = mspd_pkg::ST_MKI;
          mspd_pkg::CMD_DIRECT: state_nxt = mspd_pkg::ST_DIRECT;
          default:              state_nxt = mspd_pkg::ST_FIN;
        endcase
      end
      mspd_pkg::ST_MKI:    state_nxt = mspd_pkg::ST_MDT;
      mspd_pkg::ST_MDT:    state_nxt = mspd_pkg::ST_MKP;
      mspd_pkg::ST_MKP:    state_nxt = mspd_pkg::ST_MRT;
      mspd_pkg::ST_MRT:    state_nxt = mspd_pkg::ST_MKD;
      mspd_pkg::ST_MKD:    state_nxt = mspd_pkg::ST_DSH;
      mspd_pkg::ST_DSH:    state_nxt = mspd_pkg::ST_SUM;
      mspd_pkg::ST_SUM:    state_nxt = mspd_pkg::ST_FIN;
      mspd_pkg::ST_DIRECT: state_nxt = mspd_pkg::ST_FIN;
      mspd_pkg::ST_FIN: begin
        if (sts.out_free) state_nxt = mspd_pkg::ST_IDLE;
      end
      default: state_nxt = mspd_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd         = '0;
    cmd.mul_sel = mspd_pkg::MUL_KI;
    in_tready   = 1'b0;
    case (state_r)
      mspd_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.in_load = in_tvalid;
      end
      mspd_pkg::ST_ERR: cmd.err_load = 1'b1;
      mspd_pkg::ST_MKI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mspd_pkg::MUL_KI;
      end
      mspd_pkg::ST_MDT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mspd_pkg::MUL_DT;
      end
      mspd_pkg::ST_MKP: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = mspd_pkg::MUL_KP;
        cmd.inc_load = 1'b1;
      end
      mspd_pkg::ST_MRT: begin
        cmd.mul_en     = 1'b1;
        cmd.mul_sel    = mspd_pkg::MUL_RATE;
        cmd.p_load     = 1'b1;
        cmd.integ_load = 1'b1;
      end
      mspd_pkg::ST_MKD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mspd_pkg::MUL_KD;
      end
      mspd_pkg::ST_DSH:    cmd.d_load        = 1'b1;
      mspd_pkg::ST_SUM:    cmd.pid_commit    = 1'b1;
      mspd_pkg::ST_DIRECT: cmd.direct_commit = 1'b1;
      mspd_pkg::ST_FIN:    cmd.out_load      = sts.out_free;
      default: begin
      end
    endcase
  end

endmodule

// File: sv/mspd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mspd_dp - controller datapath
// Speed and error, one shared signed multiplier, integral and drive clamps,
// the controller state and the result register.
// ----------------------------------------------------------------------------
module mspd_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mspd_pkg::cfg_t                      cfg,
  input  mspd_pkg::dp_cmd_t                   cmd,
  output mspd_pkg::dp_sts_t                   sts,
  input  logic [1:0]                          in_cmd,
  input  logic signed [mspd_pkg::SPEED_W-1:0] in_target,
  input  logic [mspd_pkg::SPEED_W-1:0]        in_count,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mspd_pkg::SPEED_W-1:0] out_measured,
  output logic signed [mspd_pkg::SPEED_W-1:0] out_desired,
  output logic [mspd_pkg::LIMIT_W-1:0]        out_magnitude,
  output logic                                out_reverse
);

  localparam int unsigned SW = mspd_pkg::SPEED_W;
  localparam int unsigned LW = mspd_pkg::LIMIT_W;
  localparam int unsigned EW = mspd_pkg::ERR_W;
  localparam int unsigned DW = mspd_pkg::DERR_W;
  localparam int unsigned AW = mspd_pkg::MUL_A_W;
  localparam int unsigned BW = mspd_pkg::MUL_B_W;
  localparam int unsigned PW = mspd_pkg::PROD_W;
  localparam int unsigned XW = mspd_pkg::SUM_W;
  localparam int unsigned IW = mspd_pkg::INC_W;
  localparam int unsigned QW = mspd_pkg::PTERM_W;
  localparam int unsigned KW = mspd_pkg::DTERM_W;

  // tick item
  logic [1:0]           mode_r;
  logic signed [SW-1:0] target_r;
  logic signed [SW-1:0] measured_r;
  logic signed [EW-1:0] error_r;
  logic signed [DW-1:0] derr_r;

  // controller state
  logic [SW-1:0]        last_count_r;
  logic signed [SW-1:0] setpoint_r;
  logic signed [SW-1:0] accum_r;
  logic signed [EW-1:0] last_error_r;
  logic [LW-1:0]        mag_r;
  logic                 rev_r;

  // products and terms
  logic signed [PW-1:0] prod_r;
  logic signed [IW-1:0] inc_r;
  logic signed [QW-1:0] p_r;
  logic signed [SW-1:0] integ_r;
  logic signed [KW-1:0] d_r;

  // result register
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic signed [SW-1:0] out_measured_r;
  logic signed [SW-1:0] out_desired_r;
  logic [LW-1:0]        out_mag_r;
  logic                 out_rev_r;

  logic signed [SW-1:0] measured_nxt;
  logic signed [EW-1:0] error_nxt;
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod_nxt;
  logic signed [XW-1:0] integ_sum;
  logic signed [SW-1:0] integ_nxt;
  logic signed [XW-1:0] drive_sum;
  logic signed [SW-1:0] drive_pid;
  logic signed [SW-1:0] drive_direct;
  logic signed [SW-1:0] pid_abs;
  logic signed [SW-1:0] direct_abs;

  assign sts.mode     = mode_r;
  assign sts.out_free = !out_valid_r || out_ready;

  // wrapping speed and the error terms
  assign measured_nxt = signed'(in_count - last_count_r);
  assign error_nxt    = EW'(target_r) - EW'(measured_r);

  // shared multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      mspd_pkg::MUL_KI: begin
        mul_a = AW'(error_r);
        mul_b = BW'(cfg.integ_gain);
      end
      mspd_pkg::MUL_DT: begin
        mul_a = prod_r[AW-1:0];
        mul_b = signed'({{(BW-SW){1'b0}}, cfg.tick_period});
      end
      mspd_pkg::MUL_KP: begin
        mul_a = AW'(error_r);
        mul_b = BW'(cfg.prop_gain);
      end
      mspd_pkg::MUL_RATE: begin
        mul_a = AW'(derr_r);
        mul_b = signed'({{(BW-SW){1'b0}}, cfg.tick_rate});
      end
      mspd_pkg::MUL_KD: begin
        mul_a = prod_r[AW-1:0];
        mul_b = BW'(cfg.deriv_gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = PW'(mul_a) * PW'(mul_b);

  // integral update and its clamp
  assign integ_sum = XW'(accum_r) + XW'(inc_r);
  assign integ_nxt = mspd_pkg::clamp_sym(integ_sum, cfg.integ_limit);

  // output sum and clamp
  assign drive_sum = XW'(p_r) + XW'(integ_r) + XW'(d_r);
  assign drive_pid = mspd_pkg::clamp_sym(drive_sum, cfg.drive_limit);
  assign pid_abs   = drive_pid[SW-1] ? -drive_pid : drive_pid;

  // direct request clamp
  assign drive_direct = mspd_pkg::clamp_sym(XW'(target_r), mspd_pkg::DIRECT_LIMIT);
  assign direct_abs   = drive_direct[SW-1] ? -drive_direct : drive_direct;

  // tick item and work registers
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      mode_r     <= in_cmd;
      target_r   <= in_target;
      measured_r <= measured_nxt;
    end
    if (cmd.err_load) begin
      error_r <= error_nxt;
      derr_r  <= DW'(error_nxt) - DW'(last_error_r);
    end
    if (cmd.mul_en)     prod_r  <= prod_nxt;
    // floor shifts of the products
    if (cmd.inc_load)   inc_r   <= prod_r[IW+23:24];
    if (cmd.p_load)     p_r     <= prod_r[QW+7:8];
    if (cmd.integ_load) integ_r <= integ_nxt;
    if (cmd.d_load)     d_r     <= prod_r[KW+7:8];
  end

  // controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_count_r <= '0;
      setpoint_r   <= '0;
      accum_r      <= '0;
      last_error_r <= '0;
      mag_r        <= '0;
      rev_r        <= 1'b0;
    end else begin
      if (cmd.in_load) last_count_r <= in_count;
      if (cmd.pid_commit) begin
        setpoint_r   <= target_r;
        accum_r      <= integ_r;
        last_error_r <= error_r;
        mag_r        <= pid_abs[LW-1:0];
        rev_r        <= drive_pid[SW-1];
      end else if (cmd.direct_commit) begin
        setpoint_r <= drive_direct;
        mag_r      <= direct_abs[LW-1:0];
        rev_r      <= drive_direct[SW-1];
      end
    end
  end

  // result register
  assign out_valid_nxt = cmd.out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_measured_r <= measured_r;
      out_desired_r  <= setpoint_r;
      out_mag_r      <= mag_r;
      out_rev_r      <= rev_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_measured  = out_measured_r;
  assign out_desired   = out_desired_r;
  assign out_magnitude = out_mag_r;
  assign out_reverse   = out_rev_r;

endmodule

// File: sv/motor_speed_pid_drive.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_speed_pid_drive - pid speed controller with anti-windup clamp
// One result per control tick, from a sequencer over a shared multiplier.
// ----------------------------------------------------------------------------
// latency from input transfer to out_tvalid spans err, the pid or direct steps
// (none for off) and fin; next input taken in the cycle after the result is
//   registered, pid ticks paced by five products in turn through one multiplier
// a result waiting on out_tready does not block the next input transfer
// synchronous active-low reset clears state and gains, drive_limit to 255
module motor_speed_pid_drive (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [31:0]                  in_tdata,   // target_speed, encoder_count
  input  logic [1:0]                   in_tuser,   // cmd
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [47:0]                  out_tdata,  // speed_delta, speed_setpoint,
                                                   // drive_magnitude, drive_reverse
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mspd_pkg::ADDR_W-1:0]  cfg_addr,
  input  logic [mspd_pkg::SPEED_W-1:0] cfg_data
);

  mspd_pkg::cfg_t    cfg;
  mspd_pkg::dp_cmd_t dp_cmd;
  mspd_pkg::dp_sts_t dp_sts;

  logic signed [mspd_pkg::SPEED_W-1:0] measured;
  logic signed [mspd_pkg::SPEED_W-1:0] desired;
  logic [mspd_pkg::LIMIT_W-1:0]        magnitude;
  logic                                reverse;

  // register file
  mspd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer
  mspd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  // datapath
  mspd_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd           (dp_cmd),
    .sts           (dp_sts),
    .in_cmd        (in_tuser),
    .in_target     (signed'(in_tdata[15:0])),
    .in_count      (in_tdata[31:16]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_measured  (measured),
    .out_desired   (desired),
    .out_magnitude (magnitude),
    .out_reverse   (reverse)
  );

  // result packing
  assign out_tdata = {reverse, magnitude, desired, measured};

  // one tick at a time
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a tick is in flight");

  // result register loaded only when free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.out_load |-> dp_sts.out_free)
    else $error("result register overwritten");

  // a result appears only through a load
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(dp_cmd.out_load))
    else $error("result valid without load");

  // multiplier runs only for pid ticks
  a_mul_pid: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.mul_en |-> dp_sts.mode == mspd_pkg::CMD_PID)
    else $error("multiplier used outside pid mode");

endmodule

// File: tb/sv/motor_speed_pid_drive_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_speed_pid_drive_tb - self-checking bench for the pid speed drive
// Sends control ticks over the input stream and checks every result against
// a cycle-free model of the controller held in a scoreboard. Register
// settings change between bursts, with mild and extreme gains and limits,
// and both stream sides are throttled at random, apart from the last bursts.
// ----------------------------------------------------------------------------
module motor_speed_pid_drive_tb;

  // codes not covered by the package enums
  localparam logic [1:0]                  CMD_SPARE = 2'd3;
  localparam logic [mspd_pkg::ADDR_W-1:0] REG_SPARE = 3'd7;

  localparam int unsigned BURSTS     = 9;
  localparam int unsigned BURST_LEN  = 95;
  localparam int unsigned MAX_REPORT = 10;

  // expected drive results and the controller state that produces them
  class drive_tick_scoreboard;
    logic signed [15:0] kp, ki, kd;
    logic [15:0]        dt, rate;
    logic [14:0]        integ_lim, drive_lim;
    logic [15:0]        prev_count;
    logic signed [15:0] setpoint, integ_acc;
    logic signed [16:0] prev_err;
    logic [14:0]        mag_held;
    logic               rev_held;
    logic [47:0]        pending_results[$];
    int unsigned        errors;

    function void power_on();
      kp = '0;
      ki = '0;
      kd = '0;
      dt = '0;
      rate = '0;
      integ_lim = '0;
      drive_lim = 15'd255;
      prev_count = '0;
      setpoint = '0;
      integ_acc = '0;
      prev_err = '0;
      mag_held = '0;
      rev_held = 1'b0;
      errors = 0;
      pending_results.delete();
    endfunction

    function void set_reg(logic [mspd_pkg::ADDR_W-1:0] idx, logic [15:0] val);
      case (idx)
        mspd_pkg::REG_PROP_GAIN:   kp = val;
        mspd_pkg::REG_INTEG_GAIN:  ki = val;
        mspd_pkg::REG_DERIV_GAIN:  kd = val;
        mspd_pkg::REG_TICK_PERIOD: dt = val;
        mspd_pkg::REG_TICK_RATE:   rate = val;
        mspd_pkg::REG_INTEG_LIMIT: integ_lim = val[14:0];
        mspd_pkg::REG_DRIVE_LIMIT: drive_lim = val[14:0];
        default: ;
      endcase
    endfunction

    function longint limit_sym(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function void hold_drive(longint v);
      longint m;
      rev_held = (v < 0);
      m = (v < 0) ? -v : v;
      mag_held = m[14:0];
    endfunction

    // one control tick accepted by the block
    function void take_tick(logic [1:0] cmd, logic [15:0] tgt, logic [15:0] cnt);
      logic [15:0] delta;
      longint target, meas, err, inc, integ, p, d, drv;
      longint kpv, kiv, kdv, dtv, rtv, accv, perr;
      delta = cnt - prev_count;
      meas = $signed(delta);
      target = $signed(tgt);
      prev_count = cnt;
      if (cmd == mspd_pkg::CMD_PID) begin
        kpv = kp;
        kiv = ki;
        kdv = kd;
        dtv = dt;
        rtv = rate;
        accv = integ_acc;
        perr = prev_err;
        err = target - meas;
        // arithmetic shifts give floor scaling
        inc = (kiv * err * dtv) >>> 24;
        integ = limit_sym(accv + inc, integ_lim);
        p = (kpv * err) >>> 8;
        d = ((err - perr) * rtv * kdv) >>> 8;
        drv = limit_sym(p + integ + d, drive_lim);
        setpoint = tgt;
        integ_acc = integ[15:0];
        prev_err = err[16:0];
        hold_drive(drv);
      end else if (cmd == mspd_pkg::CMD_DIRECT) begin
        drv = limit_sym(target, mspd_pkg::DIRECT_LIMIT);
        setpoint = drv[15:0];
        hold_drive(drv);
      end
      pending_results.push_back({rev_held, mag_held, setpoint, delta});
    endfunction

    // one result transfer from the block
    function void compare_result(logic [47:0] got);
      logic [47:0] want;
      logic        bad;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORT) $display("unexpected result %h", got);
        return;
      end
      want = pending_results.pop_front();
      bad = (got[15:0] !== want[15:0]) || (got[31:16] !== want[31:16]) ||
            (got[46:32] !== want[46:32]) || (got[47] !== want[47]);
      if (bad) begin
        errors++;
        if (errors <= MAX_REPORT) begin
          $display("result mismatch (exp/got): measured %0d/%0d desired %0d/%0d",
                   $signed(want[15:0]), $signed(got[15:0]),
                   $signed(want[31:16]), $signed(got[31:16]));
          $display("  magnitude %0d/%0d reverse %b/%b",
                   want[46:32], got[46:32], want[47], got[47]);
        end
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [31:0]                   in_tdata = '0;
  logic [1:0]                    in_tuser = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [47:0]                   out_tdata;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [mspd_pkg::ADDR_W-1:0]   cfg_addr = '0;
  logic [mspd_pkg::SPEED_W-1:0]  cfg_data = '0;

  drive_tick_scoreboard sb;
  int unsigned          send_idle = 0;
  int unsigned          recv_idle = 0;
  logic [15:0]          enc_pos = '0;

  motor_speed_pid_drive i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side: check each transfer, throttle ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.compare_result(out_tdata);
    end
    out_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // one tick on the input stream, valid stays high into the next tick
  task automatic send_tick(input logic [1:0] cmd, input logic [15:0] tgt,
                           input logic [15:0] cnt);
    if ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {cnt, tgt};
    do @(posedge clk); while (!in_tready);
    sb.take_tick(cmd, tgt, cnt);
  endtask

  // drop valid and wait for every outstanding result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // register write, valid left high for a following write
  task automatic write_reg(input logic [mspd_pkg::ADDR_W-1:0] idx,
                           input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  task automatic write_config(input logic [15:0] kp, ki, kd, dt, rt, il, dl);
    write_reg(mspd_pkg::REG_PROP_GAIN, kp);
    write_reg(mspd_pkg::REG_INTEG_GAIN, ki);
    write_reg(mspd_pkg::REG_DERIV_GAIN, kd);
    write_reg(mspd_pkg::REG_TICK_PERIOD, dt);
    write_reg(mspd_pkg::REG_TICK_RATE, rt);
    write_reg(mspd_pkg::REG_INTEG_LIMIT, il);
    write_reg(mspd_pkg::REG_DRIVE_LIMIT, dl);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_gain();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    if (r < 40) return 16'($urandom);
    return 16'($urandom_range(0, 1536) - 768);
  endfunction

  function automatic logic [15:0] pick_unsigned(input int unsigned mild_max);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    if (r < 40) return 16'($urandom);
    return 16'($urandom_range(0, mild_max));
  endfunction

  // bit 15 is random too, the block keeps 15 bits
  function automatic logic [15:0] pick_limit();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom_range(0, 1) ? 16'h7FFF : 16'h0000;
    if (r < 35) return 16'($urandom);
    return 16'($urandom_range(20, 3000));
  endfunction

  task automatic load_config(input int unsigned burst);
    case (burst)
      1: write_config(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF,
                      16'h7FFF, 16'h7FFF);
      2: write_config(16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF,
                      pick_limit(), pick_limit());
      default: begin
        // an index past the register file must change nothing
        if (burst == 3) write_reg(REG_SPARE, 16'($urandom));
        write_config(pick_gain(), pick_gain(), pick_gain(), pick_unsigned(16'h4000),
                     pick_unsigned(300), pick_limit(), pick_limit());
      end
    endcase
  endtask

  // mostly small count steps from the last count, some anywhere
  task automatic random_tick(output logic [1:0] cmd, output logic [15:0] tgt,
                             output logic [15:0] cnt);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) cmd = mspd_pkg::CMD_PID;
    else if (r < 80) cmd = mspd_pkg::CMD_DIRECT;
    else if (r < 93) cmd = mspd_pkg::CMD_OFF;
    else cmd = CMD_SPARE;
    r = $urandom_range(0, 99);
    if (r < 80) cnt = 16'(enc_pos + $urandom_range(0, 600) - 300);
    else cnt = 16'($urandom);
    enc_pos = cnt;
    r = $urandom_range(0, 99);
    if (r < 50) tgt = 16'($urandom_range(0, 800) - 400);
    else if (r < 70) tgt = $urandom_range(0, 1) ? 16'(16'h7FFF - $urandom_range(0, 3))
                                                 : 16'(16'h8000 + $urandom_range(0, 3));
    else tgt = 16'($urandom);
  endtask

  // hand-picked ticks: wrap of the count, extremes, every mode, zero limits
  task automatic run_directed();
    write_config(16'd256, 16'd2048, 16'd64, 16'h2000, 16'd100, 16'd500, 16'd255);
    send_tick(mspd_pkg::CMD_OFF, 16'd0, 16'd5);
    send_tick(mspd_pkg::CMD_PID, 16'd100, 16'd15);
    send_tick(mspd_pkg::CMD_PID, 16'd100, 16'd25);
    send_tick(mspd_pkg::CMD_PID, 16'h8000, 16'h8019);
    send_tick(mspd_pkg::CMD_PID, 16'h7FFF, 16'h0019);
    send_tick(mspd_pkg::CMD_PID, 16'h8000, 16'h8018);
    send_tick(mspd_pkg::CMD_DIRECT, 16'h7FFF, 16'h8018);
    send_tick(mspd_pkg::CMD_DIRECT, 16'h8000, 16'h8018);
    send_tick(mspd_pkg::CMD_DIRECT, 16'h0000, 16'h8018);
    send_tick(mspd_pkg::CMD_DIRECT, 16'hFFFF, 16'h8017);
    send_tick(mspd_pkg::CMD_DIRECT, 16'd255, 16'h8017);
    send_tick(mspd_pkg::CMD_DIRECT, 16'hFF00, 16'h8017);
    send_tick(CMD_SPARE, 16'd1234, 16'hFFFF);
    send_tick(mspd_pkg::CMD_OFF, 16'hFFFB, 16'h0000);
    drain_results();
    // zero limits with extreme gains
    write_config(16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    send_tick(mspd_pkg::CMD_PID, 16'h7FFF, 16'h0100);
    send_tick(mspd_pkg::CMD_PID, 16'h8000, 16'h0100);
    send_tick(mspd_pkg::CMD_DIRECT, 16'h7FFF, 16'h0100);
    send_tick(mspd_pkg::CMD_PID, 16'd0, 16'h0100);
    drain_results();
    // widest limits, integral limit written with bit 15 set
    write_config(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
    send_tick(mspd_pkg::CMD_PID, 16'h7FFF, 16'h8100);
    send_tick(mspd_pkg::CMD_PID, 16'h7FFF, 16'h8100);
    send_tick(mspd_pkg::CMD_PID, 16'h8000, 16'h0100);
    send_tick(mspd_pkg::CMD_PID, 16'h8000, 16'h0100);
    send_tick(mspd_pkg::CMD_PID, 16'h0000, 16'h0100);
    drain_results();
  endtask

  // main sequence
  initial begin
    logic [1:0]  cmd;
    logic [15:0] tgt;
    logic [15:0] cnt;
    sb = new();
    sb.power_on();
    send_idle = 13;
    recv_idle = 59;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    enc_pos = sb.prev_count;
    for (int unsigned burst = 0; burst < BURSTS; burst++) begin
      case (burst / 3)
        0: begin
          send_idle = 13;
          recv_idle = 59;
        end
        1: begin
          send_idle = 59;
          recv_idle = 13;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      load_config(burst);
      repeat (BURST_LEN) begin
        random_tick(cmd, tgt, cnt);
        send_tick(cmd, tgt, cnt);
      end
      drain_results();
    end
    // room for any stray result
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog, 4 ms is far beyond the slowest correct run
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: filelist.f
sv/mspd_pkg.sv
sv/mspd_cfg.sv
sv/mspd_ctrl.sv
sv/mspd_dp.sv
sv/motor_speed_pid_drive.sv
tb/sv/motor_speed_pid_drive_tb.sv
